// ----- sv/tss_pkg.sv -----
// shared types and constants for the two-stack shared store
// no dependencies
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned Capacity = 32;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CntW     = 6;
  localparam int unsigned DataW    = 32;

  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
  } mem_req_t;

endpackage

// ----- sv/two_stacks_shared_store.sv -----
// the result strobe done_o is registered and rises in the cycle after the request is accepted
// throughput: one request per cycle; busy stays low, the single store port
// takes at most one read or one write per request and a pop sees a push of the cycle before
// reset: both stack counts clear, store contents are left as they are
// the receiver cannot stall; each result is shown for exactly one cycle
// depends on tss_pkg, tss_ctrl, tss_store
`timescale 1ns / 1ps

module two_stacks_shared_store
  import tss_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic                    command_i,
  input  logic                    which_stack_i,
  input  logic signed [DataW-1:0] push_value_i,
  output logic                    done_o,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         first_count_o,
  output logic [CntW-1:0]         second_count_o
);

  mem_req_t         mem_req;
  logic [DataW-1:0] rdata;
  logic             accept;
  logic             pop_ok;
  status_e          status;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  tss_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (command_i),
    .which_stack_i  (which_stack_i),
    .push_value_i   (push_value_i),
    .mem_req_o      (mem_req),
    .done_o         (done_o),
    .pop_ok_o       (pop_ok),
    .status_o       (status),
    .first_count_o  (first_count_o),
    .second_count_o (second_count_o)
  );

  tss_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign popped_value_o = pop_ok ? rdata : '0;
  assign status_o       = status;

endmodule

// ----- sv/tss_store.sv -----
// single-port synchronous store holding both stacks, with registered read data
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_store
  import tss_pkg::*;
(
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem_q [Capacity];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/tss_ctrl.sv -----
// stack pointer control: full/empty checks, store addressing, result status
// depends on tss_pkg
`timescale 1ns / 1ps

module tss_ctrl
  import tss_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic             command_i,
  input  logic             which_stack_i,
  input  logic [DataW-1:0] push_value_i,
  output mem_req_t         mem_req_o,
  output logic             done_o,
  output logic             pop_ok_o,
  output status_e          status_o,
  output logic [CntW-1:0]  first_count_o,
  output logic [CntW-1:0]  second_count_o
);

  logic [CntW-1:0] first_q, first_d;
  logic [CntW-1:0] second_q, second_d;
  logic            done_q;
  logic            pop_ok_q, pop_ok_d;
  status_e         status_q, status_d;
  logic [CntW:0]   used;
  logic            full;
  logic [CntW:0]   top_idx;

  assign used = {1'b0, first_q} + {1'b0, second_q};
  assign full = used >= (CntW+1)'(Capacity);

  always_comb begin
    first_d         = first_q;
    second_d        = second_q;
    status_d        = ST_DONE;
    pop_ok_d        = 1'b0;
    top_idx         = '0;
    mem_req_o.we    = 1'b0;
    mem_req_o.re    = 1'b0;
    mem_req_o.wdata = push_value_i;
    unique case (command_i)
      CmdPush: begin
        if (full) begin
          status_d = ST_FULL;
        end else if (!which_stack_i) begin
          top_idx      = {1'b0, first_q};
          first_d      = first_q + 1'b1;
          mem_req_o.we = accept_i;
        end else begin
          // second stack grows down from the top entry
          top_idx      = (CntW+1)'(Capacity - 1) - {1'b0, second_q};
          second_d     = second_q + 1'b1;
          mem_req_o.we = accept_i;
        end
      end
      CmdPop: begin
        if (!which_stack_i) begin
          if (first_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            top_idx      = {1'b0, first_q} - 1'b1;
            first_d      = first_q - 1'b1;
            pop_ok_d     = 1'b1;
            mem_req_o.re = accept_i;
          end
        end else begin
          if (second_q == '0) begin
            status_d = ST_EMPTY;
          end else begin
            top_idx      = (CntW+1)'(Capacity) - {1'b0, second_q};
            second_d     = second_q - 1'b1;
            pop_ok_d     = 1'b1;
            mem_req_o.re = accept_i;
          end
        end
      end
      default: ;
    endcase
    mem_req_o.addr = top_idx[AddrW-1:0];
  end

  // a write lands at the accept edge, so a pop in the next cycle already sees it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= '0;
      second_q <= '0;
      done_q   <= 1'b0;
      pop_ok_q <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      done_q <= accept_i;
      if (accept_i) begin
        first_q  <= first_d;
        second_q <= second_d;
        pop_ok_q <= pop_ok_d;
        status_q <= status_d;
      end
    end
  end

  assign done_o         = done_q;
  assign pop_ok_o       = pop_ok_q;
  assign status_o       = status_q;
  assign first_count_o  = first_q;
  assign second_count_o = second_q;

endmodule

// ----- sv/tss_checker.sv -----
// port-level checks for the two-stack shared store, bound to the top level
// depends on tss_pkg and two_stacks_shared_store
`timescale 1ns / 1ps

module tss_checker
  import tss_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic                    done_o,
  input logic signed [DataW-1:0] popped_value_o,
  input logic [1:0]              status_o,
  input logic [CntW-1:0]         first_count_o,
  input logic [CntW-1:0]         second_count_o
);

  // every request gives exactly one result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("accepted request gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without a request");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_DONE) |-> (popped_value_o == '0))
    else $error("refused request returned a value");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o == ST_DONE || status_o == ST_FULL || status_o == ST_EMPTY))
    else $error("undefined status code");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (({1'b0, first_count_o} + {1'b0, second_count_o}) <= (CntW+1)'(Capacity)))
    else $error("stacks overlap");

endmodule

bind two_stacks_shared_store tss_checker u_tss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .popped_value_o (popped_value_o),
  .status_o       (status_o),
  .first_count_o  (first_count_o),
  .second_count_o (second_count_o)
);

// ----- bench/tb_two_stacks_shared_store.sv -----
// self-checking testbench for two_stacks_shared_store: directed plan, then random request traffic
// depends on tss_pkg and the two_stacks_shared_store rtl
`timescale 1ns / 1ps

module tb_two_stacks_shared_store;
  import tss_pkg::*;

  localparam logic FirstStack  = 1'b0;
  localparam logic SecondStack = 1'b1;
  localparam int   RandomItems = 1600;

  typedef struct packed {
    logic signed [DataW-1:0] popped;
    status_e                 status;
    logic [CntW-1:0]         first_cnt;
    logic [CntW-1:0]         second_cnt;
  } stack_result_t;

  typedef struct {
    logic          cmd;
    logic          sel;
    logic [31:0]   val;
    int            reps;
    bit            pin;
    stack_result_t res;
  } plan_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic                    command_i = CmdPush;
  logic                    which_stack_i = FirstStack;
  logic signed [DataW-1:0] push_value_i = '0;
  logic                    done_o;
  logic signed [DataW-1:0] popped_value_o;
  logic [1:0]              status_o;
  logic [CntW-1:0]         first_count_o;
  logic [CntW-1:0]         second_count_o;

  // typed expectation travelling with a directed request
  bit            pin_valid = 1'b0;
  stack_result_t pin_result = '0;

  // private copy of the block state
  logic [DataW-1:0] store_model [Capacity];
  int unsigned      first_depth = 0;
  int unsigned      second_depth = 0;

  stack_result_t result_q [$];
  stack_result_t predicted, wanted;
  plan_row_t     plan [$];

  int errors = 0;
  int n_requests = 0, n_pushed = 0, n_popped = 0, n_full = 0, n_empty = 0, n_checked = 0;

  two_stacks_shared_store DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .which_stack_i (which_stack_i),
    .push_value_i  (push_value_i),
    .done_o        (done_o),
    .popped_value_o(popped_value_o),
    .status_o      (status_o),
    .first_count_o (first_count_o),
    .second_count_o(second_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("two_stacks_shared_store regression: fail");
    $finish;
  end

  function automatic stack_result_t apply_request(logic cmd, logic sel, logic [31:0] val);
    stack_result_t r;
    r = '0;
    r.status = ST_DONE;
    if (cmd == CmdPush) begin
      if (first_depth + second_depth >= Capacity) begin
        r.status = ST_FULL;
        n_full++;
      end else if (sel == FirstStack) begin
        store_model[first_depth[AddrW-1:0]] = val;
        first_depth++;
        n_pushed++;
      end else begin
        second_depth++;
        store_model[AddrW'(Capacity - second_depth)] = val;
        n_pushed++;
      end
    end else if (sel == FirstStack) begin
      if (first_depth == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        first_depth--;
        r.popped = store_model[first_depth[AddrW-1:0]];
        n_popped++;
      end
    end else begin
      if (second_depth == 0) begin
        r.status = ST_EMPTY;
        n_empty++;
      end else begin
        r.popped = store_model[AddrW'(Capacity - second_depth)];
        second_depth--;
        n_popped++;
      end
    end
    r.first_cnt  = first_depth[CntW-1:0];
    r.second_cnt = second_depth[CntW-1:0];
    return r;
  endfunction

  // inputs and outputs are both read before this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy === 1'b0) begin
        predicted = apply_request(command_i, which_stack_i, push_value_i);
        n_requests++;
        result_q.push_back(pin_valid ? pin_result : predicted);
      end
      if (done_o === 1'b1) begin
        if (result_q.size() == 0) begin
          $error("result with nothing expected: popped_value %0d status %0d",
                 popped_value_o, status_o);
          errors++;
        end else begin
          wanted = result_q.pop_front();
          n_checked++;
          if (popped_value_o !== wanted.popped) begin
            $error("popped_value: expected %0d, got %0d", wanted.popped, popped_value_o);
            errors++;
          end
          if (status_o !== wanted.status) begin
            $error("status: expected %0d, got %0d", wanted.status, status_o);
            errors++;
          end
          if (first_count_o !== wanted.first_cnt) begin
            $error("first_count: expected %0d, got %0d", wanted.first_cnt, first_count_o);
            errors++;
          end
          if (second_count_o !== wanted.second_cnt) begin
            $error("second_count: expected %0d, got %0d", wanted.second_cnt, second_count_o);
            errors++;
          end
        end
      end
    end
  end

  // holds the request until the block takes it; start is left high for the caller
  task automatic issue(input logic cmd, input logic sel, input logic [31:0] val,
                       input bit pin, input stack_result_t pinned);
    start         <= 1'b1;
    command_i     <= cmd;
    which_stack_i <= sel;
    push_value_i  <= val;
    pin_valid     <= pin;
    pin_result    <= pinned;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int cycles);
    if (cycles > 0) begin
      start     <= 1'b0;
      pin_valid <= 1'b0;
      command_i <= 1'($urandom_range(1));
      push_value_i <= $urandom;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  function automatic int pick_gap(bit busy_phase);
    int r;
    r = $urandom_range(99);
    if (busy_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic plan_row_t row(logic cmd, logic sel, logic [31:0] val, int reps,
                                    bit pin, logic [31:0] pv, status_e st, int fc, int sc);
    plan_row_t p;
    p.cmd  = cmd;
    p.sel  = sel;
    p.val  = val;
    p.reps = reps;
    p.pin  = pin;
    p.res  = '{popped: pv, status: st, first_cnt: fc[CntW-1:0], second_cnt: sc[CntW-1:0]};
    return p;
  endfunction

  initial begin
    int     target;
    int     phase_len;
    int     push_pct;
    int     second_pct;
    bit     busy_phase;
    logic   cmd;
    logic   sel;

    //            cmd      stack        value         reps pin popped        status    f   s
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  0));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  0));
    plan.push_back(row(CmdPush, FirstStack,  32'h7fff_ffff, 1, 1, 32'h0,         ST_DONE,  1,  0));
    plan.push_back(row(CmdPush, SecondStack, 32'h8000_0000, 1, 1, 32'h0,         ST_DONE,  1,  1));
    plan.push_back(row(CmdPush, FirstStack,  32'hffff_ffff, 1, 1, 32'h0,         ST_DONE,  2,  1));
    plan.push_back(row(CmdPush, SecondStack, 32'h0,         1, 1, 32'h0,         ST_DONE,  2,  2));
    plan.push_back(row(CmdPop,  SecondStack, 32'h1234_5678, 1, 1, 32'h0,         ST_DONE,  2,  1));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'hffff_ffff, ST_DONE,  1,  1));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'h7fff_ffff, ST_DONE,  0,  1));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  1));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         1, 1, 32'h8000_0000, ST_DONE,  0,  0));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  0));
    // fill the store from both ends until the tops meet
    plan.push_back(row(CmdPush, FirstStack,  32'ha5a5_a5a5, 20, 0, 32'h0,        ST_DONE,  0,  0));
    plan.push_back(row(CmdPush, SecondStack, 32'h5a5a_5a5a, 12, 0, 32'h0,        ST_DONE,  0,  0));
    plan.push_back(row(CmdPush, FirstStack,  32'h1,         1, 1, 32'h0,         ST_FULL,  20, 12));
    plan.push_back(row(CmdPush, SecondStack, 32'h1,         1, 1, 32'h0,         ST_FULL,  20, 12));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         1, 0, 32'h0,         ST_DONE,  0,  0));
    plan.push_back(row(CmdPush, FirstStack,  32'h1234_5678, 1, 1, 32'h0,         ST_DONE,  21, 11));
    plan.push_back(row(CmdPush, SecondStack, 32'h2,         1, 1, 32'h0,         ST_FULL,  21, 11));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'h1234_5678, ST_DONE,  20, 11));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         20, 0, 32'h0,        ST_DONE,  0,  0));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         11, 0, 32'h0,        ST_DONE,  0,  0));
    plan.push_back(row(CmdPop,  FirstStack,  32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  0));
    plan.push_back(row(CmdPop,  SecondStack, 32'h0,         1, 1, 32'h0,         ST_EMPTY, 0,  0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // back to back, so pops land right behind the pushes they read
    foreach (plan[k]) begin
      for (int i = 0; i < plan[k].reps; i++) begin
        issue(plan[k].cmd, plan[k].sel, plan[k].val + i, plan[k].pin, plan[k].res);
      end
    end
    idle_for(2);

    // phases lean towards filling, draining or one stack so both ends get reached
    target = n_requests + RandomItems;
    while (n_requests < target) begin
      phase_len  = $urandom_range(80, 20);
      case ($urandom_range(3))
        0:       push_pct = 15;
        1:       push_pct = 50;
        2:       push_pct = 85;
        default: push_pct = 95;
      endcase
      case ($urandom_range(2))
        0:       second_pct = 10;
        1:       second_pct = 90;
        default: second_pct = 50;
      endcase
      busy_phase = ($urandom_range(9) < 3);
      for (int i = 0; i < phase_len; i++) begin
        cmd = ($urandom_range(99) < push_pct) ? CmdPush : CmdPop;
        sel = ($urandom_range(99) < second_pct) ? SecondStack : FirstStack;
        issue(cmd, sel, pick_value(), 1'b0, '0);
        idle_for(pick_gap(busy_phase));
      end
    end

    start     <= 1'b0;
    pin_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (result_q.size() != 0) begin
      $error("%0d results never arrived", result_q.size());
      errors++;
    end

    $display("ran %0d requests: %0d pushes and %0d pops done, %0d refused full, %0d refused empty",
             n_requests, n_pushed, n_popped, n_full, n_empty);
    $display("%0d results checked, %0d mismatches", n_checked, errors);
    if (errors == 0) begin
      $display("two_stacks_shared_store regression: pass");
    end else begin
      $display("two_stacks_shared_store regression: fail");
    end
    $finish;
  end

endmodule
